// File: rtl/chm_pkg.sv
// Shared types and constants for the chained hash id map.
// No dependencies; included first by every other file.
`default_nettype none
package chm_pkg;

  // Fixed field widths
  localparam int KEY_W    = 63;
  localparam int HANDLE_W = 32;
  localparam int BC_W     = 9;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_KEY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Remainder unit result
  typedef struct packed {
    logic            done;
    logic [BC_W-1:0] rem;
  } chm_mod_rsp_t;

endpackage
`default_nettype wire

// File: rtl/chm_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on chm_pkg.
`default_nettype none
interface chm_req_if;
  import chm_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [KEY_W-1:0]    key;
  logic [HANDLE_W-1:0] handle;
  modport source (output valid, op, key, handle, input ready);
  modport sink (input valid, op, key, handle, output ready);
endinterface

interface chm_rsp_if;
  import chm_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [HANDLE_W-1:0] found_handle;
  logic [STATUS_W-1:0] status;
  modport source (output valid, found, found_handle, status, input ready);
  modport sink (input valid, found, found_handle, status, output ready);
endinterface
`default_nettype wire

// File: rtl/chm_mod_unit.sv
// Bit-serial remainder unit: key modulo a 9-bit divisor, one key bit a cycle.
// Depends on chm_pkg.
`default_nettype none
module chm_mod_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [chm_pkg::KEY_W-1:0] key,
  input  wire logic [chm_pkg::BC_W-1:0]  divisor,
  output chm_pkg::chm_mod_rsp_t         result
);
  import chm_pkg::*;

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [KEY_W-1:0] dividend;
  logic [BC_W-1:0]  div;
  logic [BC_W-1:0]  rem;
  logic [BC_W:0]    trial;
  logic [BC_W:0]    diff;
  logic [BC_W-1:0]  rem_next;

  // One restoring step: bring in the next key bit, subtract when it fits
  always_comb begin
    trial = {rem, dividend[KEY_W-1]};
    diff  = trial - {1'b0, div};
    if (trial >= {1'b0, div}) begin
      rem_next = diff[BC_W-1:0];
    end else begin
      rem_next = trial[BC_W-1:0];
    end
  end

  // Control: count down the key bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(KEY_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift and reduce
  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= key;
      div      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      dividend <= {dividend[KEY_W-2:0], 1'b0};
      rem      <= rem_next;
    end
  end

  assign result.done = done;
  assign result.rem  = rem;

endmodule
`default_nettype wire

// File: rtl/chained_hash_id_map_core.sv
// Chained hash id map: top level with sequencer, fill table and slot memories.
// Depends on chm_pkg, chm_if and chm_mod_unit.
`default_nettype none
// Maps a 63-bit object identifier to a 32-bit handle. The bucket is the key
// modulo bucket_count (clamped to 1..MAX_BUCKETS); each bucket keeps up to
// SLOTS_PER_BUCKET entries in insertion order, duplicates allowed. An insert
// of key zero answers status 1, an insert into a full bucket answers status 2
// and is dropped. A lookup answers the first matching entry of its bucket.
// One item at a time: the bucket comes from a bit-serial remainder unit, and a
// lookup then scans the slots of its bucket in order, one registered memory read
// and one compare per slot, over at most SLOTS_PER_BUCKET slots. After reset the
// fill table is cleared bucket by bucket before the first request is taken;
// bucket_count writes are taken throughout. A finished result waits in an output
// register while the next request is taken.
module chained_hash_id_map_core #(
  parameter int MAX_BUCKETS      = 256,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [chm_pkg::BC_W-1:0] cfg_wdata,
  chm_req_if.sink                      req,
  chm_rsp_if.source                    rsp
);
  import chm_pkg::*;

  localparam int DEPTH   = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int BW      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FW      = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int DIV_CAP = (MAX_BUCKETS > 511) ? 511 : MAX_BUCKETS;
  localparam logic [BC_W-1:0] DIV_CAP_W = BC_W'(DIV_CAP);
  localparam logic [FW-1:0]   SLOTS_W   = FW'(SLOTS_PER_BUCKET);
  localparam logic [BW-1:0]   LAST_BKT  = BW'(MAX_BUCKETS - 1);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_MOD      = 8'b0000_0100,
    S_FILL     = 8'b0000_1000,
    S_DECIDE   = 8'b0001_0000,
    S_SCAN_RD  = 8'b0010_0000,
    S_SCAN_CMP = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [BC_W-1:0]     bucket_count;
  logic [BC_W-1:0]     divisor;
  chm_mod_rsp_t        mod_rsp;
  logic                req_xfer;

  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [BW-1:0]       bucket;
  logic [AW-1:0]       base;
  logic [SW-1:0]       idx;
  logic [BW-1:0]       clr_idx;

  logic [FW-1:0]       fill_mem [MAX_BUCKETS];
  logic [FW-1:0]       fill_rd;
  logic                fill_we;
  logic [BW-1:0]       fill_waddr;
  logic [FW-1:0]       fill_wdata;

  logic [KEY_W-1:0]    slot_keys [DEPTH];
  logic [HANDLE_W-1:0] slot_handles [DEPTH];
  logic [KEY_W-1:0]    key_rd;
  logic [HANDLE_W-1:0] handle_rd;
  logic                slot_we;
  logic [AW-1:0]       slot_waddr;
  logic [AW-1:0]       slot_raddr;

  logic                insert_ok;
  logic                hit;
  logic                scan_last;
  logic                out_load;

  logic                res_found;
  logic [HANDLE_W-1:0] res_handle;
  logic [STATUS_W-1:0] res_status;

  logic                rsp_valid;
  logic                rsp_found;
  logic [HANDLE_W-1:0] rsp_handle;
  logic [STATUS_W-1:0] rsp_status;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BC_W'(1);
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  // Clamp the divisor to 1..MAX_BUCKETS
  always_comb begin
    if (bucket_count == '0) begin
      divisor = BC_W'(1);
    end else if (bucket_count > DIV_CAP_W) begin
      divisor = DIV_CAP_W;
    end else begin
      divisor = bucket_count;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;

  chm_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (req_xfer),
    .key     (req.key),
    .divisor (divisor),
    .result  (mod_rsp)
  );

  // Decode helpers
  assign insert_ok  = (op_q == OP_INSERT) && (key_q != '0) && (fill_rd != SLOTS_W);
  assign hit        = (key_rd == key_q);
  assign scan_last  = ((FW'(idx) + FW'(1)) == fill_rd);
  assign out_load   = (state == S_OUT) && (!rsp_valid || rsp.ready);
  assign slot_raddr = base + AW'(idx);
  assign slot_waddr = base + AW'(fill_rd);
  assign slot_we    = (state == S_DECIDE) && insert_ok;

  // Fill table write port: clearing pass or insert
  always_comb begin
    if (state == S_CLEAR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_idx;
      fill_wdata = '0;
    end else begin
      fill_we    = slot_we;
      fill_waddr = bucket;
      fill_wdata = fill_rd + FW'(1);
    end
  end

  // Fill table memory
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rd <= fill_mem[bucket];
  end

  // Slot memories
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_keys[slot_waddr]    <= key_q;
      slot_handles[slot_waddr] <= handle_q;
    end
    key_rd    <= slot_keys[slot_raddr];
    handle_rd <= slot_handles[slot_raddr];
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (clr_idx == LAST_BKT) state_next = S_IDLE;
      S_IDLE:     if (req_xfer) state_next = S_MOD;
      S_MOD:      if (mod_rsp.done) state_next = S_FILL;
      S_FILL:     state_next = S_DECIDE;
      S_DECIDE: begin
        if (op_q == OP_LOOKUP && fill_rd != '0) begin
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (hit || scan_last) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_OUT:      if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + BW'(1);
      end
    end
  end

  // Sequencer payload: capture request, bucket, scan index and result
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op_q     <= req.op;
      key_q    <= req.key;
      handle_q <= req.handle;
    end
    if (state == S_MOD && mod_rsp.done) begin
      bucket <= BW'(mod_rsp.rem);
      base   <= AW'(BW'(mod_rsp.rem) * SLOTS_PER_BUCKET);
      idx    <= '0;
    end
    if (state == S_DECIDE) begin
      res_found  <= 1'b0;
      res_handle <= '0;
      if (op_q == OP_LOOKUP) begin
        res_status <= ST_OK;
      end else if (key_q == '0) begin
        res_status <= ST_BAD_KEY;
      end else if (fill_rd == SLOTS_W) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (state == S_SCAN_CMP) begin
      if (hit) begin
        res_found  <= 1'b1;
        res_handle <= handle_rd;
      end else begin
        idx <= idx + SW'(1);
      end
    end
  end

  // Output register: hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_found  <= res_found;
      rsp_handle <= res_handle;
      rsp_status <= res_status;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.found        = rsp_found;
  assign rsp.found_handle = rsp_handle;
  assign rsp.status       = rsp_status;

  // Checks
  a_xfer_starts_mod: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state == S_MOD)
    else $error("request transfer did not start the remainder step");

  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == S_MOD)
    else $error("remainder unit finished outside the remainder step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> fill_wdata <= SLOTS_W)
    else $error("bucket fill written beyond slot count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_found) |-> rsp_status == ST_OK)
    else $error("found result with non-ok status");

endmodule
`default_nettype wire

// File: sim/chained_hash_id_map_core_tb.sv
// Self-checking testbench for chained_hash_id_map_core: inserts and lookups with
// random idling and backpressure are scored against a behavioral map in the bench.
// Depends on chm_pkg, chm_if and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_id_map_core_tb;
  import chm_pkg::*;

  localparam int MAX_BUCKETS      = 256;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int SETTLE_CYCLES    = 120;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int MAX_REPORTS      = 10;
  localparam logic [BC_W-1:0] BC_ZERO = 9'd0;
  localparam logic [BC_W-1:0] BC_ONE  = 9'd1;
  localparam logic [BC_W-1:0] BC_MAX  = 9'd256;
  localparam logic [BC_W-1:0] BC_TOP  = 9'd511;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] found_handle;
    logic [STATUS_W-1:0] status;
  } map_rsp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [BC_W-1:0] cfg_wdata;

  chm_req_if req_bus ();
  chm_rsp_if rsp_bus ();

  chained_hash_id_map_core #(
    .MAX_BUCKETS     (MAX_BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_bus.sink),
    .rsp      (rsp_bus.source)
  );

  // Bench copy of the map state
  bit [KEY_W-1:0]    map_keys    [MAX_BUCKETS*SLOTS_PER_BUCKET];
  bit [HANDLE_W-1:0] map_handles [MAX_BUCKETS*SLOTS_PER_BUCKET];
  int unsigned       map_fill    [MAX_BUCKETS];
  logic [BC_W-1:0]   bucket_cfg = BC_ONE;

  map_rsp_t          pending_rsp[$];
  bit [KEY_W-1:0]    key_pool[$];
  bit                idle_en = 1'b1;
  int                long_holds_asked = 0;
  int                err_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Effective divisor: zero acts as one, oversize clamps to the table size
  function automatic int unsigned bucket_divisor();
    if (bucket_cfg == 0) return 1;
    if (bucket_cfg > MAX_BUCKETS) return MAX_BUCKETS;
    return bucket_cfg;
  endfunction

  // Apply one request to the bench map and return the answer it must give
  function automatic map_rsp_t map_apply(logic op, logic [KEY_W-1:0] key,
                                         logic [HANDLE_W-1:0] handle);
    map_rsp_t    r;
    int unsigned bkt;
    int unsigned base;
    int unsigned fill;
    r    = '0;
    bkt  = int'(64'(key) % 64'(bucket_divisor()));
    base = bkt * SLOTS_PER_BUCKET;
    fill = map_fill[bkt];
    if (op == OP_INSERT) begin
      if (key == 0) begin
        r.status = ST_BAD_KEY;
      end else if (fill >= SLOTS_PER_BUCKET) begin
        r.status = ST_FULL;
      end else begin
        map_keys[base + fill]    = key;
        map_handles[base + fill] = handle;
        map_fill[bkt]            = fill + 1;
      end
    end else begin
      for (int i = 0; i < fill; i++) begin
        if (map_keys[base + i] == key) begin
          r.found        = 1'b1;
          r.found_handle = map_handles[base + i];
          break;
        end
      end
    end
    return r;
  endfunction

  // Offer one request, hold it until the transfer, then record the expected answer
  task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
    if (idle_en && $urandom_range(0, 11) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.op     <= op;
    req_bus.key    <= key;
    req_bus.handle <= handle;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pending_rsp.push_back(map_apply(op, key, handle));
    if (op == OP_INSERT && key != 0) begin
      key_pool.push_back(key);
      if (key_pool.size() > 128) void'(key_pool.pop_front());
    end
  endtask

  // Drop valid, drain every outstanding answer, then let the core settle
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bucket_count(logic [BC_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    bucket_cfg = value;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) r = r >> $urandom_range(0, 62);
    return r[KEY_W-1:0];
  endfunction

  function automatic logic [HANDLE_W-1:0] rand_handle();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Single bucket: bad key, empty lookups, extremes, duplicates, full bucket
  task automatic test_directed_basics();
    set_bucket_count(BC_ONE);
    send_item(OP_INSERT, '0, 32'hDEAD_BEEF);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_LOOKUP, KEY_MAX, '0);
    send_item(OP_INSERT, KEY_MAX, '1);
    send_item(OP_LOOKUP, KEY_MAX, 32'h1234_5678);
    send_item(OP_INSERT, 63'd1, '0);
    send_item(OP_LOOKUP, 63'd1, '1);
    send_item(OP_INSERT, 63'd1, 32'd5);
    send_item(OP_LOOKUP, 63'd1, '0);
    for (int k = 2; k <= 6; k++) send_item(OP_INSERT, KEY_W'(k), 32'h100 + k);
    send_item(OP_INSERT, 63'd9, 32'h99);
    send_item(OP_LOOKUP, 63'd9, '0);
    send_item(OP_LOOKUP, 63'd6, '0);
    send_item(OP_LOOKUP, 63'd7, '0);
  endtask

  // Divisor zero and oversize, then a count change that strands older entries
  task automatic test_divisor_edges();
    set_bucket_count(BC_ZERO);
    send_item(OP_INSERT, 63'd77, 32'h77);
    send_item(OP_LOOKUP, 63'd2, '0);
    set_bucket_count(BC_TOP);
    send_item(OP_INSERT, 63'd255, 32'hAAAA_5555);
    send_item(OP_INSERT, 63'd511, 32'h5555_AAAA);
    send_item(OP_INSERT, 63'd256, 32'h0000_0256);
    send_item(OP_LOOKUP, 63'd511, '0);
    send_item(OP_LOOKUP, 63'd255, '0);
    set_bucket_count(BC_MAX);
    send_item(OP_LOOKUP, 63'd511, '0);
    send_item(OP_INSERT, KEY_MAX - 63'd1, 32'h0F0F_0F0F);
    send_item(OP_LOOKUP, KEY_MAX - 63'd1, '0);
    set_bucket_count(9'd2);
    send_item(OP_LOOKUP, 63'd1, '0);
    send_item(OP_LOOKUP, 63'd4, '0);
  endtask

  // Mostly well-formed traffic: hits, collisions and duplicates, with some noise
  task automatic test_random_traffic(int n_items, logic [BC_W-1:0] bc);
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                op;
    int                  pick;
    set_bucket_count(bc);
    for (int i = 0; i < n_items; i++) begin
      pick   = $urandom_range(0, 99);
      handle = rand_handle();
      key    = rand_key();
      op     = OP_INSERT;
      if (key_pool.size() != 0 && pick < 75) begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (pick < 20 && key[KEY_W-1] == 1'b0) begin
          key = key + KEY_W'(bucket_divisor()) * KEY_W'($urandom_range(1, 5));
        end else if (pick >= 30) begin
          op = OP_LOOKUP;
        end
      end else if (pick < 97) begin
        op = (pick < 88) ? OP_INSERT : OP_LOOKUP;
      end else begin
        key = '0;
        op  = logic'($urandom_range(0, 1));
      end
      send_item(op, key, handle);
    end
  endtask

  // Hold the answer side off for a long stretch while requests keep coming
  task automatic test_backpressure();
    bit saved;
    saved = idle_en;
    set_bucket_count(BC_MAX);
    idle_en = 1'b0;
    long_holds_asked++;
    for (int i = 0; i < 24; i++) begin
      send_item((i % 3 == 2) ? OP_LOOKUP : OP_INSERT,
                (i % 3 == 2) ? KEY_W'(i + 1000) : KEY_W'(i + 1001), $urandom);
    end
    idle_en = saved;
  endtask

  // Answer side ready: long holds on request, random idle bursts otherwise
  initial begin : rsp_ready_drive
    int hold_left;
    int holds_served;
    hold_left     = 0;
    holds_served  = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_bus.ready <= 1'b0;
      end else if (holds_served != long_holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES - 1;
        rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 13);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Score each answer transfer against the oldest expectation
  always @(posedge clk) begin : rsp_check
    map_rsp_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("[%0t] unexpected answer: found=%b handle=%h status=%0d", $time,
                   rsp_bus.found, rsp_bus.found_handle, rsp_bus.status);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.found !== want.found || rsp_bus.found_handle !== want.found_handle ||
            rsp_bus.status !== want.status) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch: exp found=%b handle=%h status=%0d, got found=%b handle=%h status=%0d",
                     $time, want.found, want.found_handle, want.status,
                     rsp_bus.found, rsp_bus.found_handle, rsp_bus.status);
        end
      end
    end
  end

  // Abort when neither side has moved a transfer for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst) begin
      quiet = 0;
    end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("** chained_hash_id_map_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    req_bus.valid  <= 1'b0;
    req_bus.op     <= OP_INSERT;
    req_bus.key    <= '0;
    req_bus.handle <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_divisor_edges();
    test_backpressure();
    test_random_traffic(400, BC_MAX);
    test_random_traffic(350, BC_W'($urandom_range(2, 255)));
    test_random_traffic(300, BC_TOP);
    test_random_traffic(300, BC_W'($urandom_range(1, 64)));
    test_random_traffic(150, BC_ZERO);
    test_random_traffic(250, BC_W'($urandom_range(128, 256)));
    idle_en = 1'b0;
    test_random_traffic(150, BC_MAX);

    wait_idle();
    if (pending_rsp.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("** chained_hash_id_map_core: PASSED **");
    end else begin
      $display("** chained_hash_id_map_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: chained_hash_id_map_core.f
rtl/chm_pkg.sv
rtl/chm_if.sv
rtl/chm_mod_unit.sv
rtl/chained_hash_id_map_core.sv
sim/chained_hash_id_map_core_tb.sv
